// ===== rtl/wdm_alu_pkg.sv =====
package wdm_alu_pkg;

	localparam int W = 64;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_SCUP  = 3'd4;
	localparam logic [2:0] OP_SCDN  = 3'd5;

	typedef struct packed {
		logic [2:0]   opcode;
		logic [W-1:0] a_low;
		logic [W-1:0] a_mid;
		logic [W-1:0] a_high;
		logic [W-1:0] b_low;
		logic [W-1:0] b_mid;
		logic [W-1:0] b_high;
		logic [4:0]   a_scale;
		logic         a_sign;
	} req_t;

	typedef struct packed {
		logic [W-1:0] r_low;
		logic [W-1:0] r_mid;
		logic [W-1:0] r_high;
		logic [4:0]   r_scale;
		logic         r_sign;
		logic         overflow_flag;
		logic         error_flag;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic iterate;
		logic last;
	} sts_t;

endpackage

// ===== rtl/wdm_alu_dp.sv =====
module wdm_alu_dp import wdm_alu_pkg::*; #(
	parameter int MANT_BITS = 192,
	parameter int SOFT_BITS = 96,
	parameter int MAX_SCALE = 28
) (
	input  logic clk,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int CW = $clog2(MANT_BITS + 1);
	localparam logic [4:0] LIM = (MAX_SCALE < 31) ? 5'(MAX_SCALE) : 5'd31;

	logic [MANT_BITS-1:0] a_q, b_q, acc_q, rem_q;
	logic [CW-1:0]        cnt_q;
	logic [2:0]           op_q;
	logic [4:0]           scale_q;
	logic                 sign_q, ov_q, err_q;
	logic [191:0]         r_q;
	logic [4:0]           rscale_q;
	logic                 rov_q, rerr_q;

	logic [3*W-1:0]       a_in, b_in;
	logic [MANT_BITS-1:0] a_m, b_m, bsel;
	logic [MANT_BITS:0]   sum, carries;
	logic                 ov_add;
	logic [MANT_BITS:0]   rsh, rdiff;
	logic                 ge;

	assign a_in = {req.a_high, req.a_mid, req.a_low};
	assign b_in = {req.b_high, req.b_mid, req.b_low};
	assign a_m  = a_in[MANT_BITS-1:0];
	assign b_m  = b_in[MANT_BITS-1:0];

	// one adder for add and each multiply partial sum
	assign sum = {1'b0, acc_q} + {1'b0, b_q};
	assign carries = sum ^ {1'b0, acc_q} ^ {1'b0, b_q};
	always_comb begin
		ov_add = 1'b0;
		for (int k = 0; k <= MANT_BITS; k++)
			if (k >= SOFT_BITS && carries[k]) ov_add = 1'b1;
	end

	// restoring divide step on remainder
	assign rsh   = {rem_q, a_q[MANT_BITS-1]};
	assign rdiff = rsh - {1'b0, b_q};
	assign ge    = (rsh >= {1'b0, b_q});

	assign bsel = (req.opcode == OP_SCUP) ? MANT_BITS'(10) :
		(req.opcode == OP_SCDN) ? MANT_BITS'(10) : b_m;

	assign sts.iterate = (op_q == OP_MUL) || (op_q == OP_SCUP) ||
		(op_q == OP_DIV && !err_q) || (op_q == OP_SCDN);
	assign sts.last = (cnt_q == CW'(MANT_BITS - 1));

	// operand and iteration registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= a_m;
			b_q     <= bsel;
			acc_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			op_q    <= req.opcode;
			scale_q <= req.a_scale;
			sign_q  <= req.a_sign;
			ov_q    <= 1'b0;
			err_q   <= (req.opcode == OP_DIV && b_m == '0) || (req.opcode > OP_SCDN);
			// add and subtract sum a with the (negated) b on the shared adder
			if (req.opcode == OP_ADD || req.opcode == OP_SUB) begin
				acc_q <= a_m;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
			if (op_q == OP_MUL || op_q == OP_SCUP) begin
				if (a_q[0]) begin
					acc_q <= sum[MANT_BITS-1:0];
					if (ov_add) ov_q <= 1'b1;
				end
				a_q <= a_q >> 1;
				b_q <= b_q << 1;
			end else begin
				a_q <= a_q << 1;
				if (ge) begin
					rem_q <= rdiff[MANT_BITS-1:0];
					acc_q <= {acc_q[MANT_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rsh[MANT_BITS-1:0];
					acc_q <= {acc_q[MANT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// result formation
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			r_q      <= '0;
			rscale_q <= scale_q;
			rov_q    <= ov_q;
			rerr_q   <= err_q;
			case (op_q)
				OP_ADD: begin
					r_q[MANT_BITS-1:0] <= sum[MANT_BITS-1:0];
					rov_q <= ov_add;
				end
				OP_SUB: r_q[MANT_BITS-1:0] <= sum[MANT_BITS-1:0];
				OP_MUL, OP_SCUP: r_q[MANT_BITS-1:0] <= acc_q;
				OP_DIV: if (!err_q) r_q[MANT_BITS-1:0] <= acc_q;
				OP_SCDN: r_q[MANT_BITS-1:0] <= acc_q;
				default: ;
			endcase
			if (op_q == OP_SCUP) begin
				if (scale_q >= LIM) rerr_q <= 1'b1;
				else rscale_q <= scale_q + 5'd1;
			end
			if (op_q == OP_SCDN) begin
				if (scale_q == 5'd0) rerr_q <= 1'b1;
				else rscale_q <= scale_q - 5'd1;
			end
		end
	end

	assign rsp.r_low         = r_q[W-1:0];
	assign rsp.r_mid         = r_q[2*W-1:W];
	assign rsp.r_high        = r_q[3*W-1:2*W];
	assign rsp.r_scale       = rscale_q;
	assign rsp.r_sign        = sign_q;
	assign rsp.overflow_flag = rov_q;
	assign rsp.error_flag    = rerr_q;

endmodule

// ===== rtl/wdm_alu_ctrl.sv =====
module wdm_alu_ctrl import wdm_alu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	// only iterating ops advance the datapath loop
	assign cmd.step   = (state_q == S_RUN) && sts.iterate;
	assign cmd.finish = (state_q == S_FIN);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RUN;
				S_RUN: begin
					if (!sts.iterate || sts.last) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/wide_decimal_mantissa_alu_core.sv =====
// add, subtract, divide by zero and unknown opcodes skip the datapath loop; multiply,
// divide and scale ops take one step per mantissa bit through the one-bit-per-cycle shift-add and
// restoring-divide loop in the datapath
// throughput: one request at a time, next request taken after the result leaves
// reset: arst_n asynchronously returns the controller to idle; datapath has no reset
module wide_decimal_mantissa_alu_core import wdm_alu_pkg::*; #(
	parameter int MANT_BITS = 192,
	parameter int SOFT_BITS = 96,
	parameter int MAX_SCALE = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	cmd_t cmd;
	sts_t sts;
	req_t req_sub;

	// subtract goes through the adder path with b negated (two's complement)
	always_comb begin
		req_sub = in_data;
		if (in_data.opcode == OP_SUB) begin
			{req_sub.b_high, req_sub.b_mid, req_sub.b_low} =
				-{in_data.b_high, in_data.b_mid, in_data.b_low};
		end
	end

	wdm_alu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	wdm_alu_dp #(
		.MANT_BITS(MANT_BITS), .SOFT_BITS(SOFT_BITS), .MAX_SCALE(MAX_SCALE)
	) u_dp (
		.clk(clk), .req(req_sub), .cmd(cmd), .sts(sts), .rsp(out_data)
	);

	// datapath only loads when idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !in_stall) else $error("load while busy");
	// a result is shown only after the finish step
	a_out_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish)) else $error("result without finish");
	// no new request accepted while a result waits
	a_no_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept during output");

endmodule
